### rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int CHUNK_BITS  = 32;
  localparam int NUM_CHUNKS  = MAX_ENTRIES / CHUNK_BITS;
  localparam int POS_W       = $clog2(CHUNK_BITS);
  localparam int CHUNK_W     = $clog2(NUM_CHUNKS);
  localparam int ADDR_W      = CHUNK_W + 1;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [CHUNK_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_INODE   = 2'd1,
    ST_NO_CLUSTER = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FREE = 2'd2
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    word_t             wr_data;
  } mem_req_t;

endpackage
`default_nettype wire

### rtl/core/bfa_map_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_map_mem
// Free-map word store for both pools, with per-row valid bits so that an
// unwritten row reads as all free.
// ----------------------------------------------------------------------------
module bfa_map_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bfa_pkg::mem_req_t req,
  output      bfa_pkg::word_t    rd_data
);
  import bfa_pkg::*;

  localparam int DEPTH = 2 * NUM_CHUNKS;

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  word_t            rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '1;

endmodule
`default_nettype wire

### rtl/core/bfa_ffs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ffs
// Find-first-set unit: lowest set bit of one map chunk.
// ----------------------------------------------------------------------------
module bfa_ffs (
  input  wire bfa_pkg::word_t             word,
  output      logic                       found,
  output      logic [bfa_pkg::POS_W-1:0]  pos
);
  import bfa_pkg::*;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: scans one chunk per cycle through the find-first-set unit,
// handles free read-modify-write and registers the result.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic                       in_cmd,
  input  wire logic                       in_pool,
  input  wire logic [bfa_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [bfa_pkg::CNT_W-1:0]  count,
  input  wire bfa_pkg::word_t             map_word,
  output      bfa_pkg::mem_req_t          req,
  output      logic                       out_valid,
  output      logic [bfa_pkg::IDX_W-1:0]  out_result_index,
  output      logic [1:0]                 out_status
);
  import bfa_pkg::*;

  state_t               state_r, state_nxt;
  logic                 pool_r, pool_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  status_t              out_st_r, out_st_nxt;

  logic [CNT_W-1:0]     eff_cnt;
  logic [CNT_W-1:0]     cnt_m1;
  logic [CHUNK_W-1:0]   last_chunk;
  logic                 accept;
  word_t                mask;
  word_t                cand;
  logic                 hit;
  logic [POS_W-1:0]     hit_pos;
  status_t              fail_st;

  assign accept  = start && (state_r == S_IDLE);
  assign eff_cnt = (count > CNT_MAX) ? CNT_MAX : count;
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign last_chunk = cnt_m1[POS_W +: CHUNK_W];
  assign fail_st = pool_r ? ST_NO_CLUSTER : ST_NO_INODE;

  // valid-entry mask for the chunk under scan
  always_comb begin
    if (CNT_W'(chunk_r) < (cnt_r >> POS_W)) begin
      mask = '1;
    end else begin
      mask = ~('1 << cnt_r[POS_W-1:0]);
    end
  end

  assign cand = map_word & mask;

  bfa_ffs u_ffs (
    .word  (cand),
    .found (hit),
    .pos   (hit_pos)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_ALLOC) begin
            state_nxt = (eff_cnt == '0) ? S_IDLE : S_SCAN;
          end else begin
            state_nxt = (CNT_W'(in_entry_index) < eff_cnt) ? S_FREE : S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (hit || chunk_r == last_chunk) begin
          state_nxt = S_IDLE;
        end
      end
      S_FREE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pool_nxt      = pool_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    chunk_nxt     = chunk_r;
    out_valid_nxt = 1'b0;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    req           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pool_nxt  = in_pool;
          idx_nxt   = in_entry_index;
          cnt_nxt   = eff_cnt;
          chunk_nxt = '0;
          if (in_cmd == CMD_ALLOC) begin
            if (eff_cnt == '0) begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_st_nxt    = in_pool ? ST_NO_CLUSTER : ST_NO_INODE;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = {in_pool, CHUNK_W'(0)};
            end
          end else begin
            if (CNT_W'(in_entry_index) < eff_cnt) begin
              req.rd_en   = 1'b1;
              req.rd_addr = {in_pool, in_entry_index[POS_W +: CHUNK_W]};
            end else begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = '0;
              out_st_nxt    = ST_RANGE;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          req.wr_en     = 1'b1;
          req.wr_addr   = {pool_r, chunk_r};
          req.wr_data   = map_word & ~(CHUNK_BITS'(1) << hit_pos);
          out_valid_nxt = 1'b1;
          out_idx_nxt   = {chunk_r, hit_pos};
          out_st_nxt    = ST_OK;
        end else if (chunk_r == last_chunk) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          out_st_nxt    = fail_st;
        end else begin
          chunk_nxt   = chunk_r + CHUNK_W'(1);
          req.rd_en   = 1'b1;
          req.rd_addr = {pool_r, chunk_nxt};
        end
      end
      S_FREE: begin
        req.wr_en     = 1'b1;
        req.wr_addr   = {pool_r, idx_r[POS_W +: CHUNK_W]};
        req.wr_data   = map_word | (CHUNK_BITS'(1) << idx_r[POS_W-1:0]);
        out_valid_nxt = 1'b1;
        out_idx_nxt   = idx_r;
        out_st_nxt    = ST_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pool_r    <= pool_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    chunk_r   <= chunk_nxt;
    out_idx_r <= out_idx_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;
  assign out_status       = out_st_r;

endmodule
`default_nettype wire

### rtl/core/bitmap_first_free_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_top
// First-fit allocator over two 1024-entry free maps (inode, data cluster).
//
// An item is taken when start is high and busy is low. in_cmd selects
// allocate (lowest free entry below the entry count) or free (in_entry_index).
// Each item gives exactly one result, shown for one cycle with out_valid;
// the receiver cannot stall it.
// An out-of-range free or an allocate with a zero count is answered from
// idle; a free reads the map word, then writes it back with the entry set;
// an allocate scans up to 32 chunks of 32 entries in turn, stopping at the
// first hit. The scan reads one map word per cycle and runs it through a
// single find-first-set unit. busy stays high until the result is shown,
// and the next item may be taken in the result cycle, so one item is in flight at a time.
// cfg_we/cfg_wdata write the entry count; write it only while idle.
// Reset marks every entry free at once and sets the count to 1024.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic                       in_cmd,
  input  wire logic                       in_pool,
  input  wire logic [bfa_pkg::IDX_W-1:0]  in_entry_index,
  output      logic                       out_valid,
  output      logic [bfa_pkg::IDX_W-1:0]  out_result_index,
  output      logic [1:0]                 out_status,
  input  wire logic                       cfg_we,
  input  wire logic [bfa_pkg::CNT_W-1:0]  cfg_wdata
);
  import bfa_pkg::*;

  logic [CNT_W-1:0] count_r;
  mem_req_t         req;
  word_t            map_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  bfa_map_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (map_word)
  );

  bfa_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_pool          (in_pool),
    .in_entry_index   (in_entry_index),
    .count            (count_r),
    .map_word         (map_word),
    .req              (req),
    .out_valid        (out_valid),
    .out_result_index (out_result_index),
    .out_status       (out_status)
  );

endmodule
`default_nettype wire

### rtl/core/bfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       out_valid,
  input wire logic [bfa_pkg::IDX_W-1:0]  out_result_index,
  input wire logic [1:0]                 out_status
);
  import bfa_pkg::*;

  // failed item carries a zero index
  a_fail_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_index == '0)
    else $error("failed item with nonzero index");

  // accepted item is either in flight or done in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item dropped");

  // busy ends only with a delivered result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // no result while still working on an item
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind bitmap_first_free_allocator_top bfa_checker u_bfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_index (out_result_index),
  .out_status       (out_status)
);
`default_nettype wire
